// ===== sv/swsm_pkg.sv =====
`timescale 1ns / 1ps
package swsm_pkg;

	localparam int WINDOW = 8;
	localparam int AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int CW = $clog2(WINDOW + 1);

	localparam int DATA_W = 32;
	localparam int SUM_W = 37;
	localparam int FILL_W = 6;
	localparam int OUT_W = SUM_W + DATA_W + FILL_W;
	localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

	localparam logic REQ_PUSH = 1'b0;
	localparam logic REQ_CLEAR = 1'b1;

	typedef struct packed {
		logic          start;
		logic [CW-1:0] count;
	} rank_ctl_t;

endpackage

// ===== sv/swsm_ram.sv =====
`timescale 1ns / 1ps
module swsm_ram (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic        [swsm_pkg::AW-1:0]       waddr,
	input  logic signed [swsm_pkg::DATA_W-1:0]   wdata,
	input  logic        [swsm_pkg::AW-1:0]       a_addr,
	input  logic        [swsm_pkg::AW-1:0]       b_addr,
	output logic signed [swsm_pkg::DATA_W-1:0]   a_data,
	output logic signed [swsm_pkg::DATA_W-1:0]   b_data
);

	logic signed [swsm_pkg::DATA_W-1:0] mem [swsm_pkg::WINDOW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		a_data <= mem[a_addr];
		b_data <= mem[b_addr];
	end

endmodule

// ===== sv/swsm_rank.sv =====
`timescale 1ns / 1ps
module swsm_rank (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  swsm_pkg::rank_ctl_t                  ctl,
	input  logic signed [swsm_pkg::DATA_W-1:0]   a_data,
	input  logic signed [swsm_pkg::DATA_W-1:0]   b_data,
	output logic        [swsm_pkg::AW-1:0]       a_addr,
	output logic        [swsm_pkg::AW-1:0]       b_addr,
	output logic                                 done,
	output logic signed [swsm_pkg::DATA_W-1:0]   lo_val,
	output logic signed [swsm_pkg::DATA_W-1:0]   hi_val
);

	logic                                run_q;
	logic        [swsm_pkg::CW-1:0]      n_q;
	logic        [swsm_pkg::AW-1:0]      i_q;
	logic        [swsm_pkg::AW-1:0]      j_q;
	logic                                v_s1;
	logic                                last_s1;
	logic                                fin_s1;
	logic        [swsm_pkg::CW-1:0]      less_q;
	logic        [swsm_pkg::CW-1:0]      eq_q;
	logic signed [swsm_pkg::DATA_W-1:0]  lo_q;
	logic signed [swsm_pkg::DATA_W-1:0]  hi_q;
	logic                                done_q;

	logic [swsm_pkg::CW-1:0] nm1;
	logic [swsm_pkg::CW-1:0] k_lo;
	logic [swsm_pkg::CW-1:0] k_hi;
	logic [swsm_pkg::CW-1:0] lt_c;
	logic [swsm_pkg::CW-1:0] le_c;
	logic                    j_end;
	logic                    i_end;

	assign nm1   = n_q - 1'b1;
	assign k_lo  = nm1 >> 1;
	assign k_hi  = n_q >> 1;
	assign j_end = (swsm_pkg::CW'(j_q) == nm1);
	assign i_end = (swsm_pkg::CW'(i_q) == nm1);
	assign lt_c  = less_q + swsm_pkg::CW'(b_data < a_data);
	assign le_c  = lt_c + eq_q + swsm_pkg::CW'(b_data == a_data);

	assign a_addr = i_q;
	assign b_addr = j_q;
	assign done   = done_q;
	assign lo_val = lo_q;
	assign hi_val = hi_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= 1'b0;
			n_q     <= '0;
			i_q     <= '0;
			j_q     <= '0;
			v_s1    <= 1'b0;
			last_s1 <= 1'b0;
			fin_s1  <= 1'b0;
			less_q  <= '0;
			eq_q    <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= v_s1 && fin_s1;
			v_s1   <= run_q;
			if (ctl.start) begin
				run_q  <= 1'b1;
				n_q    <= ctl.count;
				i_q    <= '0;
				j_q    <= '0;
				less_q <= '0;
				eq_q   <= '0;
			end else begin
				if (run_q) begin
					last_s1 <= j_end;
					fin_s1  <= j_end && i_end;
					if (j_end) begin
						j_q <= '0;
						if (i_end) begin
							run_q <= 1'b0;
						end else begin
							i_q <= i_q + 1'b1;
						end
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
				if (v_s1) begin
					if (last_s1) begin
						less_q <= '0;
						eq_q   <= '0;
					end else begin
						less_q <= lt_c;
						eq_q   <= eq_q + swsm_pkg::CW'(b_data == a_data);
					end
				end
			end
		end
	end

	// a candidate holds the wanted rank when no more than k values lie below it and more than k lie at or below it
	always_ff @(posedge clk) begin
		if (v_s1 && last_s1) begin
			if (lt_c <= k_lo && k_lo < le_c) begin
				lo_q <= a_data;
			end
			if (lt_c <= k_hi && k_hi < le_c) begin
				hi_q <= a_data;
			end
		end
	end

	a_issue_follows_run: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> $past(run_q))
		else $error("compare stage active without an issued read");

	a_counts_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		!ctl.start |-> (less_q + eq_q) <= n_q)
		else $error("rank counts exceed fill count");

endmodule

// ===== sv/sliding_window_sum_median.sv =====
`timescale 1ns / 1ps
// a push gives its result once the rank scan has compared every pair of the n values held (n = 8 when full)
// no new request is accepted until the last result is registered; the rank scan runs over the two memory read ports
// a clear request gives its all-zero result without a rank scan
// the result register lets the next request in while a result waits on m_tready
// reset: asynchronous, active low; empties the window; memory contents are not cleared
module sliding_window_sum_median (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	input  logic [swsm_pkg::DATA_W-1:0]            s_tdata,  // value
	input  logic                                   s_tuser,  // req_type
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	output logic [swsm_pkg::OUT_TDATA_W-1:0]       m_tdata   // window_sum, median, fill_count
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_UPD  = 4'b0010,
		ST_SCAN = 4'b0100,
		ST_FIN  = 4'b1000
	} state_t;

	state_t                               state_q;
	logic        [swsm_pkg::AW-1:0]       wpos_q;
	logic        [swsm_pkg::CW-1:0]       cnt_q;
	logic signed [swsm_pkg::SUM_W-1:0]    total_q;
	logic signed [swsm_pkg::DATA_W-1:0]   value_q;
	logic                                 clr_q;
	logic                                 out_valid_q;
	logic        [swsm_pkg::OUT_W-1:0]    out_q;

	logic                                 accept;
	logic                                 full;
	logic                                 out_free;
	logic        [swsm_pkg::CW-1:0]       cnt_next;
	logic signed [swsm_pkg::SUM_W-1:0]    old_ext;
	logic signed [swsm_pkg::SUM_W-1:0]    new_ext;
	logic signed [swsm_pkg::DATA_W:0]     pair;
	logic signed [swsm_pkg::DATA_W:0]     pair_adj;
	logic signed [swsm_pkg::DATA_W-1:0]   med;

	logic        [swsm_pkg::AW-1:0]       a_addr;
	logic        [swsm_pkg::AW-1:0]       b_addr;
	logic        [swsm_pkg::AW-1:0]       rank_a_addr;
	logic signed [swsm_pkg::DATA_W-1:0]   a_data;
	logic signed [swsm_pkg::DATA_W-1:0]   b_data;
	logic                                 rank_done;
	logic signed [swsm_pkg::DATA_W-1:0]   lo_val;
	logic signed [swsm_pkg::DATA_W-1:0]   hi_val;
	swsm_pkg::rank_ctl_t                  rank_ctl;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign full     = (cnt_q == swsm_pkg::CW'(swsm_pkg::WINDOW));
	assign cnt_next = full ? cnt_q : cnt_q + 1'b1;
	assign out_free = !out_valid_q || m_tready;

	assign old_ext = full ? swsm_pkg::SUM_W'(a_data) : '0;
	assign new_ext = swsm_pkg::SUM_W'(value_q);

	// pair sum halved toward zero
	assign pair     = (swsm_pkg::DATA_W + 1)'(lo_val) + (swsm_pkg::DATA_W + 1)'(hi_val);
	assign pair_adj = pair + (swsm_pkg::DATA_W + 1)'(pair[swsm_pkg::DATA_W]);
	assign med      = clr_q ? '0 : pair_adj[swsm_pkg::DATA_W:1];

	// prefetch the departing entry while idle
	assign a_addr = (state_q == ST_SCAN) ? rank_a_addr : wpos_q;

	assign rank_ctl.start = (state_q == ST_UPD);
	assign rank_ctl.count = cnt_next;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = swsm_pkg::OUT_TDATA_W'(out_q);

	swsm_ram u_ram (
		.clk    (clk),
		.we     (state_q == ST_UPD),
		.waddr  (wpos_q),
		.wdata  (value_q),
		.a_addr (a_addr),
		.b_addr (b_addr),
		.a_data (a_data),
		.b_data (b_data)
	);

	swsm_rank u_rank (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (rank_ctl),
		.a_data (a_data),
		.b_data (b_data),
		.a_addr (rank_a_addr),
		.b_addr (b_addr),
		.done   (rank_done),
		.lo_val (lo_val),
		.hi_val (hi_val)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wpos_q      <= '0;
			cnt_q       <= '0;
			total_q     <= '0;
			clr_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (s_tuser == swsm_pkg::REQ_CLEAR) begin
							wpos_q  <= '0;
							cnt_q   <= '0;
							total_q <= '0;
							clr_q   <= 1'b1;
							state_q <= ST_FIN;
						end else begin
							clr_q   <= 1'b0;
							state_q <= ST_UPD;
						end
					end
				end
				ST_UPD: begin
					total_q <= total_q - old_ext + new_ext;
					cnt_q   <= cnt_next;
					if (swsm_pkg::CW'(wpos_q) == swsm_pkg::CW'(swsm_pkg::WINDOW - 1)) begin
						wpos_q <= '0;
					end else begin
						wpos_q <= wpos_q + 1'b1;
					end
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (rank_done) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			value_q <= s_tdata;
		end
		if (state_q == ST_FIN && out_free) begin
			out_q <= {swsm_pkg::FILL_W'(cnt_q), med, total_q};
		end
	end

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= swsm_pkg::CW'(swsm_pkg::WINDOW))
		else $error("fill count above window size");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && clr_q) |-> (cnt_q == '0 && total_q == '0 && wpos_q == '0))
		else $error("clear left window state behind");

	a_done_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rank_done |-> state_q == ST_SCAN)
		else $error("rank scan finished outside scan state");

	a_push_counts: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_UPD |=> cnt_q != '0)
		else $error("push left the window empty");

endmodule
